>>> rtl/core/dad_pkg.sv
// Shared types, constants and calendar helpers for the date adder.
// No dependencies.
package dad_pkg;

	localparam int unsigned MaxYear      = 9999;
	localparam int unsigned LeapCycle    = 400;
	localparam int unsigned CenturyLen   = 100;
	localparam int unsigned DaysLeapYear = 366;
	localparam int unsigned DaysYear     = 365;
	localparam int unsigned FebLeap      = 29;
	localparam int unsigned FebPlain     = 28;
	localparam int unsigned MonthsPerYr  = 12;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_CHECK,
		ST_ACC,
		ST_FIRST,
		ST_YEAR,
		ST_MWALK,
		ST_FIN_OK,
		ST_FIN_BAD,
		ST_FIN_OVER
	} dad_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MOD,
		OP_ACC,
		OP_FIRST,
		OP_YEAR,
		OP_MWALK,
		OP_OUT_OK,
		OP_OUT_BAD,
		OP_OUT_OVER
	} dad_op_t;

	typedef struct packed {
		logic mod_done;
		logic bad;
		logic acc_done;
		logic first_in;
		logic year_fit;
		logic over;
		logic mw_done;
		logic out_free;
	} dad_sts_t;

	// r is the year modulo 400
	function automatic logic leap_of(input logic [8:0] r);
		leap_of = (r[1:0] == 2'd0) && (r != 9'(CenturyLen)) &&
			(r != 9'(2 * CenturyLen)) && (r != 9'(3 * CenturyLen));
	endfunction

	function automatic logic [4:0] dim(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = leap ? 5'(FebLeap) : 5'(FebPlain);
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd31;
		endcase
		dim = len;
	endfunction

	function automatic logic [8:0] diy(input logic leap);
		diy = leap ? 9'(DaysLeapYear) : 9'(DaysYear);
	endfunction

endpackage

>>> rtl/core/dad_in_if.sv
// Request channel of the date adder: start date and day count.
// Depends on nothing.
interface dad_in_if;
	logic        valid;
	logic        ready;
	logic [4:0]  day;
	logic [3:0]  month;
	logic [13:0] year;
	logic [15:0] days_to_add;

	modport source (output valid, day, month, year, days_to_add, input ready);
	modport sink (input valid, day, month, year, days_to_add, output ready);
endinterface

>>> rtl/core/dad_out_if.sv
// Response channel of the date adder: resulting date and flags.
// Depends on nothing.
interface dad_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  new_day;
	logic [3:0]  new_month;
	logic [13:0] new_year;
	logic        overflow;
	logic        bad_input;

	modport source (output valid, new_day, new_month, new_year, overflow, bad_input,
		input ready);
	modport sink (input valid, new_day, new_month, new_year, overflow, bad_input,
		output ready);
endinterface

>>> rtl/core/date_add_days.sv
// Gregorian date adder top level: controller plus datapath behind two channels.
// Depends on dad_pkg, dad_in_if, dad_out_if, dad_ctrl, dad_dp.
//
// channel  dir  payload
// req      in   day[4:0] month[3:0] year[13:0] days_to_add[15:0]
// rsp      out  new_day[4:0] new_month[3:0] new_year[13:0] overflow bad_input
//
// One item at a time: accept, year reduction (subtracting only from year 400 up),
// check, month sum, first year, year walk, month walk and result write, plus any
// wait on rsp.ready; a bad date goes from the check straight to the write. The year
// walk, one year per cycle in the shared datapath, is the longest step.
// arst_n clears the controller and the result valid; no clearing pass.
// A result waits in its register while the next item is accepted and worked on.
module date_add_days import dad_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	dad_in_if.sink    req,
	dad_out_if.source rsp
);

	dad_op_t  op;
	dad_sts_t sts;

	dad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.op       (op)
	);

	dad_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.day         (req.day),
		.month       (req.month),
		.year        (req.year),
		.days_to_add (req.days_to_add),
		.sts         (sts),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.new_day     (rsp.new_day),
		.new_month   (rsp.new_month),
		.new_year    (rsp.new_year),
		.overflow    (rsp.overflow),
		.bad_input   (rsp.bad_input)
	);

endmodule

>>> rtl/core/dad_dp.sv
// Datapath of the date adder: working registers, calendar arithmetic, result register.
// Depends on dad_pkg.
module dad_dp import dad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dad_op_t     op,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [13:0] year,
	input  logic [15:0] days_to_add,
	output dad_sts_t    sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  new_day,
	output logic [3:0]  new_month,
	output logic [13:0] new_year,
	output logic        overflow,
	output logic        bad_input
);

	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [13:0] ny_q;
	logic [13:0] red_q;
	logic [15:0] x_q;
	logic [8:0]  doy_q;
	logic [3:0]  mcnt_q;
	logic        out_valid_q;
	logic [4:0]  new_day_q;
	logic [3:0]  new_month_q;
	logic [13:0] new_year_q;
	logic        overflow_q;
	logic        bad_input_q;

	logic        leap;
	logic [8:0]  year_len;
	logic [8:0]  rem;
	logic [4:0]  mlen;
	logic [13:0] red_next;
	logic [20:0] red_prod;
	logic [5:0]  red_quo;
	logic [13:0] red_sub;

	assign leap     = leap_of(red_q[8:0]);
	assign year_len = diy(leap);
	assign rem      = year_len - doy_q;
	assign mlen     = dim(mcnt_q, leap);
	assign red_next = (red_q == 14'(LeapCycle - 1)) ? 14'd0 : red_q + 14'd1;

	// year / 400 as (year / 16) / 25, the division by 25 by reciprocal multiplication
	assign red_prod = {11'd0, red_q[13:4]} * 21'd1311;
	assign red_quo  = red_prod[20:15];
	assign red_sub  = {8'd0, red_quo} * 14'(LeapCycle);

	always_comb begin
		sts.mod_done = red_q < 14'(LeapCycle);
		sts.bad      = (m_q == 4'd0) || (m_q > 4'(MonthsPerYr)) || (ny_q == 14'd0) ||
			(ny_q > 14'(MaxYear)) || (d_q == 5'd0) || (d_q > dim(m_q, leap));
		sts.acc_done = mcnt_q == m_q;
		sts.first_in = x_q <= {7'd0, rem};
		sts.year_fit = x_q <= {7'd0, year_len};
		sts.over     = ny_q > 14'(MaxYear);
		sts.mw_done  = (mcnt_q == 4'(MonthsPerYr)) || (doy_q <= {4'd0, mlen});
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				d_q    <= day;
				m_q    <= month;
				ny_q   <= year;
				red_q  <= year;
				x_q    <= days_to_add;
				doy_q  <= {4'd0, day};
				mcnt_q <= 4'd1;
			end
			OP_MOD: begin
				red_q <= red_q - red_sub;
			end
			OP_ACC: begin
				doy_q  <= doy_q + {4'd0, mlen};
				mcnt_q <= mcnt_q + 4'd1;
			end
			OP_FIRST: begin
				if (sts.first_in) begin
					doy_q  <= doy_q + x_q[8:0];
					mcnt_q <= 4'd1;
				end else begin
					x_q   <= x_q - {7'd0, rem};
					ny_q  <= ny_q + 14'd1;
					red_q <= red_next;
				end
			end
			OP_YEAR: begin
				if (sts.year_fit) begin
					doy_q  <= x_q[8:0];
					mcnt_q <= 4'd1;
				end else begin
					x_q   <= x_q - {7'd0, year_len};
					ny_q  <= ny_q + 14'd1;
					red_q <= red_next;
				end
			end
			OP_MWALK: begin
				doy_q  <= doy_q - {4'd0, mlen};
				mcnt_q <= mcnt_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_OUT_OK: begin
				new_day_q   <= doy_q[4:0];
				new_month_q <= mcnt_q;
				new_year_q  <= ny_q;
				overflow_q  <= 1'b0;
				bad_input_q <= 1'b0;
			end
			OP_OUT_BAD: begin
				new_day_q   <= 5'd0;
				new_month_q <= 4'd0;
				new_year_q  <= 14'd0;
				overflow_q  <= 1'b0;
				bad_input_q <= 1'b1;
			end
			OP_OUT_OVER: begin
				new_day_q   <= 5'd31;
				new_month_q <= 4'(MonthsPerYr);
				new_year_q  <= 14'(MaxYear);
				overflow_q  <= 1'b1;
				bad_input_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_OUT_OK || op == OP_OUT_BAD || op == OP_OUT_OVER) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign new_day   = new_day_q;
	assign new_month = new_month_q;
	assign new_year  = new_year_q;
	assign overflow  = overflow_q;
	assign bad_input = bad_input_q;

`ifndef SYNTHESIS
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_OUT_OK || op == OP_OUT_BAD || op == OP_OUT_OVER) |->
		(!out_valid_q || out_ready))
		else $error("result written over an item not yet taken");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(overflow_q && bad_input_q))
		else $error("overflow and bad_input both set");

	a_ok_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_OUT_OK) |=> (new_month_q >= 4'd1 && new_month_q <= 4'(MonthsPerYr) &&
		new_day_q != 5'd0))
		else $error("good result with day or month out of range");
`endif

endmodule

>>> rtl/core/dad_ctrl.sv
// Controller of the date adder: sequences load, reduction, walks and result write.
// Depends on dad_pkg.
module dad_ctrl import dad_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dad_sts_t sts,
	output dad_op_t  op
);

	dad_state_t st_q;
	dad_state_t st_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_next;
		end
	end

	always_comb begin
		st_next = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) st_next = ST_MOD;
			end
			ST_MOD: begin
				if (sts.mod_done) st_next = ST_CHECK;
			end
			ST_CHECK: begin
				st_next = sts.bad ? ST_FIN_BAD : ST_ACC;
			end
			ST_ACC: begin
				if (sts.acc_done) st_next = ST_FIRST;
			end
			ST_FIRST: begin
				st_next = sts.first_in ? ST_MWALK : ST_YEAR;
			end
			ST_YEAR: begin
				if (sts.year_fit) st_next = sts.over ? ST_FIN_OVER : ST_MWALK;
			end
			ST_MWALK: begin
				if (sts.mw_done) st_next = ST_FIN_OK;
			end
			ST_FIN_OK, ST_FIN_BAD, ST_FIN_OVER: begin
				if (sts.out_free) st_next = ST_IDLE;
			end
			default: begin
				st_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		op       = OP_NONE;
		in_ready = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = OP_LOAD;
			end
			ST_MOD: begin
				if (!sts.mod_done) op = OP_MOD;
			end
			ST_ACC: begin
				if (!sts.acc_done) op = OP_ACC;
			end
			ST_FIRST: begin
				op = OP_FIRST;
			end
			ST_YEAR: begin
				op = OP_YEAR;
			end
			ST_MWALK: begin
				if (!sts.mw_done) op = OP_MWALK;
			end
			ST_FIN_OK: begin
				if (sts.out_free) op = OP_OUT_OK;
			end
			ST_FIN_BAD: begin
				if (sts.out_free) op = OP_OUT_BAD;
			end
			ST_FIN_OVER: begin
				if (sts.out_free) op = OP_OUT_OVER;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_starts_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (st_q == ST_MOD))
		else $error("accepted item did not start the year reduction");

	a_mod_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MOD) |=> (st_q == ST_MOD || st_q == ST_CHECK))
		else $error("year reduction left to a wrong state");

	a_year_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_YEAR && sts.year_fit && sts.over) |=> (st_q == ST_FIN_OVER))
		else $error("year past limit not flagged");
`endif

endmodule
